/* src/sps_pkg.sv */
// Shared types and constants for the slot power sequencer.
// Used by every other file of the project; depends on nothing else.
package sps_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int NUM_ON_LEVELS = 2;
  localparam int PIN_W = MAX_SLOTS * NUM_ON_LEVELS;
  localparam int TIME_W = 32;
  localparam int MS_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_VALID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_POLARITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREINIT_OFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILIZE = 3'd5;

  localparam logic [MS_W-1:0] PREINIT_OFF_RST = 16'd100;
  localparam logic [MS_W-1:0] CYCLE_OFF_RST = 16'd500;
  localparam logic [MS_W-1:0] STABILIZE_RST = 16'd100;

  typedef enum logic [2:0] {
    PH_PREINIT = 3'd0,
    PH_PENDING = 3'd1,
    PH_WAIT = 3'd2,
    PH_ON_LOW = 3'd3,
    PH_ON_HIGH = 3'd4
  } phase_t;

  typedef struct packed {
    logic [MS_W-1:0] preinit_off;
    logic [MS_W-1:0] cycle_off;
    logic [MS_W-1:0] stabilize;
  } dwell_cfg_t;

  typedef struct packed {
    logic off;
    logic low_on;
  } pin_cmd_t;

endpackage

/* src/sps_slot.sv */
// One slot's phase chain: phase register, phase timestamp and dwell comparator.
// Depends on sps_pkg for the phase type, dwell configuration and pin commands.
module sps_slot (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [sps_pkg::TIME_W-1:0]  now_ms,
  input  sps_pkg::dwell_cfg_t         dwell,
  output sps_pkg::phase_t             phase_nxt,
  output sps_pkg::pin_cmd_t           cmd
);

  sps_pkg::phase_t             phase_r;
  logic [sps_pkg::TIME_W-1:0]  since_r;
  logic [sps_pkg::TIME_W-1:0]  since_nxt;
  logic [sps_pkg::TIME_W-1:0]  delta;
  logic [sps_pkg::MS_W-1:0]    dwell_sel;
  logic                        elapsed;

  always_comb begin
    phase_nxt = phase_r;
    since_nxt = since_r;
    cmd = '0;
    delta = now_ms - since_r;
    unique case (phase_r)
      sps_pkg::PH_PREINIT: dwell_sel = dwell.preinit_off;
      sps_pkg::PH_PENDING: dwell_sel = dwell.cycle_off;
      sps_pkg::PH_WAIT:    dwell_sel = dwell.stabilize;
      default:             dwell_sel = '0;
    endcase
    elapsed = delta > {{(sps_pkg::TIME_W - sps_pkg::MS_W){1'b0}}, dwell_sel};
    if (step_en && elapsed) begin
      unique case (phase_r)
        sps_pkg::PH_PREINIT: begin
          phase_nxt = sps_pkg::PH_PENDING;
          since_nxt = now_ms;
          cmd.off = 1'b1;
        end
        sps_pkg::PH_PENDING: begin
          phase_nxt = sps_pkg::PH_WAIT;
          since_nxt = now_ms;
          cmd.low_on = 1'b1;
        end
        sps_pkg::PH_WAIT: begin
          phase_nxt = sps_pkg::PH_ON_LOW;
          since_nxt = now_ms;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sps_pkg::PH_PREINIT;
      since_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      since_r <= since_nxt;
    end
  end

endmodule

/* src/slot_power_sequencer_top.sv */
// Slot power sequencer top level: input register, slot lanes, pin latch and result register.
// Depends on sps_pkg and sps_slot.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall  | func, time_now_ms, slot
//   out_    | result    | out_valid/out_stall| slot_stable, slot_phase, pin_levels, pin_driven
//   cfg_    | write     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// Each request passes from the input register into the result register and waits there until
// it is taken; one request is taken every cycle unless a stalled result holds the input register.
// All slot lanes compare their dwell times in parallel in the cycle the request commits.
// Reset is synchronous and active low; it clears phases, timestamps, pins and the start flag.
// A stalled result holds the result register, and the input register then stalls the input.
module slot_power_sequencer_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [31:0]                       in_time_now_ms,
  input  logic [3:0]                        in_slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_slot_stable,
  output logic [2:0]                        out_slot_phase,
  output logic [sps_pkg::PIN_W-1:0]         out_pin_levels,
  output logic [sps_pkg::PIN_W-1:0]         out_pin_driven,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  logic [sps_pkg::MAX_SLOTS-1:0]  slot_present_r;
  logic [sps_pkg::PIN_W-1:0]      pin_valid_r;
  logic [sps_pkg::PIN_W-1:0]      on_polarity_r;
  sps_pkg::dwell_cfg_t            dwell_r;

  logic                           s1_valid_r;
  logic [1:0]                     s1_func_r;
  logic [sps_pkg::TIME_W-1:0]     s1_now_r;
  logic [3:0]                     s1_slot_r;

  logic                           out_valid_r;
  logic                           out_stable_r;
  sps_pkg::phase_t                out_phase_r;
  logic [sps_pkg::PIN_W-1:0]      level_r;
  logic [sps_pkg::PIN_W-1:0]      level_nxt;
  logic [sps_pkg::PIN_W-1:0]      driven_r;
  logic [sps_pkg::PIN_W-1:0]      driven_nxt;
  logic                           started_r;
  logic                           started_nxt;

  logic                           commit;
  logic                           is_tick;
  logic                           is_start;
  logic [sps_pkg::MAX_SLOTS-1:0]  present_v;
  sps_pkg::phase_t                ph_all [sps_pkg::MAX_SLOTS];
  sps_pkg::pin_cmd_t              cmd_all [sps_pkg::MAX_SLOTS];
  logic [3:0]                     rq;
  logic                           stable_nxt;
  sps_pkg::phase_t                phase_nxt;

  assign commit = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !commit;
  assign cfg_ready = 1'b1;
  assign is_tick = commit && (s1_func_r == sps_pkg::FUNC_TICK) && started_r;
  assign is_start = commit && (s1_func_r == sps_pkg::FUNC_START);

  always_comb begin
    for (int i = 0; i < sps_pkg::MAX_SLOTS; i++) begin
      present_v[i] = slot_present_r[i] && (i < NUM_SLOTS);
    end
  end

  for (genvar g = 0; g < sps_pkg::MAX_SLOTS; g++) begin : g_slot
    if (g < NUM_SLOTS) begin : g_lane
      sps_slot u_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (is_tick && present_v[g]),
        .now_ms    (s1_now_r),
        .dwell     (dwell_r),
        .phase_nxt (ph_all[g]),
        .cmd       (cmd_all[g])
      );
    end else begin : g_absent
      assign ph_all[g] = sps_pkg::PH_PREINIT;
      assign cmd_all[g] = '0;
    end
  end

  always_comb begin
    logic off_req;
    level_nxt = level_r;
    driven_nxt = driven_r;
    for (int s = 0; s < sps_pkg::MAX_SLOTS; s++) begin
      off_req = (is_start && present_v[s]) || cmd_all[s].off;
      for (int l = 0; l < sps_pkg::NUM_ON_LEVELS; l++) begin
        if (pin_valid_r[s*sps_pkg::NUM_ON_LEVELS + l] && (off_req || cmd_all[s].low_on)) begin
          level_nxt[s*sps_pkg::NUM_ON_LEVELS + l] =
            (cmd_all[s].low_on && (l == 0)) ? on_polarity_r[s*sps_pkg::NUM_ON_LEVELS + l]
                                            : !on_polarity_r[s*sps_pkg::NUM_ON_LEVELS + l];
          driven_nxt[s*sps_pkg::NUM_ON_LEVELS + l] = 1'b1;
        end
      end
    end
    started_nxt = started_r || is_start;
  end

  always_comb begin
    rq = present_v[s1_slot_r] ? s1_slot_r : 4'd0;
    if (present_v[rq]) begin
      phase_nxt = ph_all[rq];
      stable_nxt = (phase_nxt == sps_pkg::PH_ON_LOW) || (phase_nxt == sps_pkg::PH_ON_HIGH);
    end else begin
      phase_nxt = sps_pkg::PH_PREINIT;
      stable_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_present_r <= '0;
      pin_valid_r <= '0;
      on_polarity_r <= '0;
      dwell_r.preinit_off <= sps_pkg::PREINIT_OFF_RST;
      dwell_r.cycle_off <= sps_pkg::CYCLE_OFF_RST;
      dwell_r.stabilize <= sps_pkg::STABILIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sps_pkg::CFG_SLOT_PRESENT: slot_present_r <= cfg_wdata[sps_pkg::MAX_SLOTS-1:0];
        sps_pkg::CFG_PIN_VALID:    pin_valid_r <= cfg_wdata;
        sps_pkg::CFG_ON_POLARITY:  on_polarity_r <= cfg_wdata;
        sps_pkg::CFG_PREINIT_OFF:  dwell_r.preinit_off <= cfg_wdata[sps_pkg::MS_W-1:0];
        sps_pkg::CFG_CYCLE_OFF:    dwell_r.cycle_off <= cfg_wdata[sps_pkg::MS_W-1:0];
        sps_pkg::CFG_STABILIZE:    dwell_r.stabilize <= cfg_wdata[sps_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      level_r <= '0;
      driven_r <= '0;
      started_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      level_r <= level_nxt;
      driven_r <= driven_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r <= in_func;
      s1_now_r <= in_time_now_ms;
      s1_slot_r <= in_slot;
    end
    if (commit) begin
      out_stable_r <= stable_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot_stable = out_stable_r;
  assign out_slot_phase = out_phase_r;
  assign out_pin_levels = level_r;
  assign out_pin_driven = driven_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held request and a held result");

  a_no_drive_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (driven_r == '0))
    else $error("pin driven before the start request");

  a_stable_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stable_r) |->
      (out_phase_r == sps_pkg::PH_ON_LOW || out_phase_r == sps_pkg::PH_ON_HIGH ||
       out_phase_r == sps_pkg::PH_PREINIT))
    else $error("stable answer with a phase that is not on");

endmodule

/* sim/slot_report_checker.sv */
// Checker for the slot power sequencer: it follows register writes and requests, predicts
// each result, and compares it with what the block returns. Depends on sps_pkg.
module slot_report_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [31:0]               in_time_now_ms,
  input  logic [3:0]                in_slot,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_slot_stable,
  input  logic [2:0]                out_slot_phase,
  input  logic [sps_pkg::PIN_W-1:0] out_pin_levels,
  input  logic [sps_pkg::PIN_W-1:0] out_pin_driven,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_wdata,
  output int                        mismatch_count,
  output int                        reports_owed,
  output int                        reports_checked
);
  import sps_pkg::*;

  typedef struct packed {
    logic             stable;
    logic [2:0]       phase;
    logic [PIN_W-1:0] levels;
    logic [PIN_W-1:0] driven;
  } slot_report_t;

  logic [MAX_SLOTS-1:0] present;
  logic [PIN_W-1:0]     pin_valid;
  logic [PIN_W-1:0]     on_polarity;
  logic [MS_W-1:0]      preinit_dwell;
  logic [MS_W-1:0]      cycle_dwell;
  logic [MS_W-1:0]      stable_dwell;

  phase_t               slot_ph [MAX_SLOTS];
  logic [TIME_W-1:0]    since [MAX_SLOTS];
  logic [PIN_W-1:0]     pin_level;
  logic [PIN_W-1:0]     pin_out;
  logic                 armed;

  slot_report_t         expected_reports [$];
  int                   errors;
  int                   checked;

  function automatic void drive_pin(input int bit_i, input logic turn_on);
    if (pin_valid[bit_i]) begin
      pin_level[bit_i] = on_polarity[bit_i] ^ ~turn_on;
      pin_out[bit_i] = 1'b1;
    end
  endfunction

  function automatic slot_report_t advance_and_report(input logic [1:0] func,
                                                      input logic [TIME_W-1:0] now,
                                                      input logic [3:0] slot);
    slot_report_t rep;
    logic [3:0] sel;
    if (func == FUNC_START) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        if (present[s]) begin
          drive_pin(2 * s, 1'b0);
          drive_pin(2 * s + 1, 1'b0);
        end
      end
      armed = 1'b1;
    end else if (func == FUNC_TICK && armed) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        if (present[s]) begin
          case (slot_ph[s])
            PH_PREINIT: begin
              if ((now - since[s]) > preinit_dwell) begin
                drive_pin(2 * s, 1'b0);
                drive_pin(2 * s + 1, 1'b0);
                slot_ph[s] = PH_PENDING;
                since[s] = now;
              end
            end
            PH_PENDING: begin
              if ((now - since[s]) > cycle_dwell) begin
                drive_pin(2 * s + 1, 1'b0);
                drive_pin(2 * s, 1'b1);
                slot_ph[s] = PH_WAIT;
                since[s] = now;
              end
            end
            PH_WAIT: begin
              if ((now - since[s]) > stable_dwell) begin
                slot_ph[s] = PH_ON_LOW;
                since[s] = now;
              end
            end
            default: ;
          endcase
        end
      end
    end
    sel = present[slot] ? slot : 4'd0;
    if (present[sel]) begin
      rep.phase = slot_ph[sel];
      rep.stable = (slot_ph[sel] == PH_ON_LOW) || (slot_ph[sel] == PH_ON_HIGH);
    end else begin
      rep.phase = PH_PREINIT;
      rep.stable = 1'b1;
    end
    rep.levels = pin_level;
    rep.driven = pin_out;
    return rep;
  endfunction

  function automatic void flag(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (errors < 10) begin
      $display("mismatch on %s: expected 0x%08h, got 0x%08h", field, want_v, got_v);
    end
    errors++;
  endfunction

  always @(posedge clk) begin
    slot_report_t want;
    if (!rst_n) begin
      present = '0;
      pin_valid = '0;
      on_polarity = '0;
      preinit_dwell = PREINIT_OFF_RST;
      cycle_dwell = CYCLE_OFF_RST;
      stable_dwell = STABILIZE_RST;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        slot_ph[s] = PH_PREINIT;
        since[s] = '0;
      end
      pin_level = '0;
      pin_out = '0;
      armed = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOT_PRESENT: present = cfg_wdata[MAX_SLOTS-1:0];
          CFG_PIN_VALID:    pin_valid = cfg_wdata;
          CFG_ON_POLARITY:  on_polarity = cfg_wdata;
          CFG_PREINIT_OFF:  preinit_dwell = cfg_wdata[MS_W-1:0];
          CFG_CYCLE_OFF:    cycle_dwell = cfg_wdata[MS_W-1:0];
          CFG_STABILIZE:    stable_dwell = cfg_wdata[MS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_reports.insert(expected_reports.size(),
                                advance_and_report(in_func, in_time_now_ms, in_slot));
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (errors < 10) begin
            $display("result arrived with no request outstanding");
          end
          errors++;
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (out_slot_stable !== want.stable) flag("slot_stable", want.stable, out_slot_stable);
          if (out_slot_phase !== want.phase) flag("slot_phase", want.phase, out_slot_phase);
          if (out_pin_levels !== want.levels) flag("pin_levels", want.levels, out_pin_levels);
          if (out_pin_driven !== want.driven) flag("pin_driven", want.driven, out_pin_driven);
        end
      end
    end
    mismatch_count <= errors;
    reports_owed <= expected_reports.size();
    reports_checked <= checked;
  end

endmodule

/* sim/testbench.sv */
// Top of the slot power sequencer testbench: clock, reset, register settings and request
// stimulus with random idling and output stalls. Depends on sps_pkg,
// slot_power_sequencer_top and slot_report_checker.
module testbench;
  import sps_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PER_SETTING = 215;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_func = FUNC_QUERY;
  logic [31:0]           in_time_now_ms = '0;
  logic [3:0]            in_slot = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_slot_stable;
  logic [2:0]            out_slot_phase;
  logic [PIN_W-1:0]      out_pin_levels;
  logic [PIN_W-1:0]      out_pin_driven;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_wdata = '0;

  int                    mismatches;
  int                    owed;
  int                    checked;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;
  int                    requests_sent = 0;
  int                    settings_used = 0;
  logic [31:0]           clock_ms = '0;
  logic [31:0]           step_max = 32'd3;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  slot_power_sequencer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_time_now_ms(in_time_now_ms), .in_slot(in_slot),
    .out_valid(out_valid), .out_stall(out_stall), .out_slot_stable(out_slot_stable),
    .out_slot_phase(out_slot_phase), .out_pin_levels(out_pin_levels),
    .out_pin_driven(out_pin_driven),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  slot_report_checker monitor (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_time_now_ms(in_time_now_ms), .in_slot(in_slot),
    .out_valid(out_valid), .out_stall(out_stall), .out_slot_stable(out_slot_stable),
    .out_slot_phase(out_slot_phase), .out_pin_levels(out_pin_levels),
    .out_pin_driven(out_pin_driven),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatches), .reports_owed(owed), .reports_checked(checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[slot_power_sequencer_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_setting(input logic [15:0] pres, input logic [31:0] valid_mask,
                                 input logic [31:0] polarity, input logic [15:0] pre_ms,
                                 input logic [15:0] cyc_ms, input logic [15:0] stab_ms);
    logic [15:0] longest;
    write_reg(CFG_SLOT_PRESENT, {16'h0, pres});
    write_reg(CFG_PIN_VALID, valid_mask);
    write_reg(CFG_ON_POLARITY, polarity);
    write_reg(CFG_PREINIT_OFF, {16'h0, pre_ms});
    write_reg(CFG_CYCLE_OFF, {16'h0, cyc_ms});
    write_reg(CFG_STABILIZE, {16'h0, stab_ms});
    cfg_valid <= 1'b0;
    longest = pre_ms;
    if (cyc_ms > longest) longest = cyc_ms;
    if (stab_ms > longest) longest = stab_ms;
    step_max = {16'h0, longest} / 2 + 32'd3;
    settings_used++;
  endtask

  task automatic send_request(input logic [1:0] func, input logic [31:0] now,
                              input logic [3:0] slot);
    int gap;
    gap = 0;
    while (gap < 1000 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_time_now_ms <= now;
    in_slot <= slot;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    logic [1:0] func;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 4) func = FUNC_START;
      else if (r < 28) func = FUNC_QUERY;
      else func = FUNC_TICK;
      if ($urandom_range(39) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(step_max);
      send_request(func, clock_ms, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FUNC_QUERY, 32'd0, 4'd3);
    send_request(FUNC_TICK, 32'd500, 4'd0);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 4'd15);
    drain();

    program_setting(16'h0005, 32'h0000_0033, 32'h0000_0021, 16'd10, 16'd20, 16'd5);
    send_request(FUNC_TICK, 32'd1000, 4'd0);
    send_request(FUNC_START, 32'd0, 4'd2);
    send_request(FUNC_TICK, 32'd10, 4'd0);
    send_request(FUNC_TICK, 32'd11, 4'd0);
    send_request(FUNC_TICK, 32'd31, 4'd2);
    send_request(FUNC_TICK, 32'd32, 4'd0);
    send_request(FUNC_TICK, 32'd37, 4'd0);
    send_request(FUNC_TICK, 32'd38, 4'd2);
    send_request(FUNC_QUERY, 32'd38, 4'd1);
    send_request(FUNC_QUERY, 32'd38, 4'd2);
    send_request(FUNC_QUERY, 32'd38, 4'd15);
    send_request(FUNC_UNUSED, 32'd39, 4'd0);
    send_request(FUNC_START, 32'd40, 4'd0);
    clock_ms = 32'd40;
    run_random(RANDOM_PER_SETTING);
    drain();

    for (int p = 1; p < 8; p++) begin
      case (p)
        1: program_setting(16'h0000, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0);
        2: program_setting(16'h00F0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_setting(16'h0F10, $urandom(), $urandom(), 16'($urandom_range(300)),
                           16'($urandom_range(300)), 16'($urandom_range(300)));
        4: program_setting(16'h7000 | 16'($urandom()), $urandom(), $urandom(),
                           16'($urandom_range(50)), 16'($urandom_range(900)),
                           16'($urandom_range(50)));
        5: begin
          program_setting(16'h8001, $urandom(), $urandom(), 16'($urandom_range(2000)),
                          16'($urandom_range(2000)), 16'($urandom_range(2000)));
          clock_ms = 32'hFFFF_FF00;
        end
        6: program_setting(16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'd0, 16'd0, 16'd0);
        default: program_setting(16'($urandom()), $urandom(), $urandom(),
                                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      run_random(RANDOM_PER_SETTING);
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
    end

    $display("Covered %0d requests under %0d register settings; %0d results compared.",
             requests_sent, settings_used, checked);
    if (owed != 0) begin
      $display("%0d expected results never arrived", owed);
    end
    if (mismatches == 0 && owed == 0) begin
      $display("[slot_power_sequencer_top] OK");
    end else begin
      $display("[slot_power_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/sps_pkg.sv
src/sps_slot.sv
src/slot_power_sequencer_top.sv
sim/slot_report_checker.sv
sim/testbench.sv
